FILE: rtl/zfe_pkg.sv
// ----------------------------------------------------------------------------
// ZMODEM frame encoder package
// Shared types, byte codes and CRC helpers for the frame encoder core.
// ----------------------------------------------------------------------------
package zfe_pkg;

  localparam int OBUF_DEPTH = 11;
  localparam int CNT_W      = $clog2(OBUF_DEPTH + 1);

  // Input item kinds.
  localparam logic [1:0] MODE_DATA    = 2'd0;
  localparam logic [1:0] MODE_HDR_BEG = 2'd1;
  localparam logic [1:0] MODE_HDR_END = 2'd2;
  localparam logic [1:0] MODE_SUB_END = 2'd3;

  // Frame-end selector for ZCRCW.
  localparam logic [1:0] FE_ZCRCW = 2'd3;

  localparam logic [7:0] ZPAD_B   = 8'h2A;
  localparam logic [7:0] ZDLE_B   = 8'h18;
  localparam logic [7:0] ZBIN_B   = 8'h41;
  localparam logic [7:0] ZBIN32_B = 8'h43;
  localparam logic [7:0] XON_B    = 8'h11;
  localparam logic [7:0] ZCRCE_B  = 8'h68;
  localparam logic [7:0] ESC_XOR  = 8'h40;
  localparam logic [6:0] AT_LOW7  = 7'h40;

  localparam logic [31:0] POLY32 = 32'hEDB88320;
  localparam logic [15:0] POLY16 = 16'h1021;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [1:0] frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  function automatic logic [31:0] crc_init(input logic is32);
    return {32{is32}};
  endfunction

  // One byte through the selected CRC; in 16-bit mode the upper half stays zero.
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b,
                                           input logic is32);
    logic [31:0] c;
    logic [15:0] h;
    c = crc ^ {24'h0, b};
    h = crc[15:0] ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ POLY32) : (c >> 1);
      h = h[15] ? ((h << 1) ^ POLY16) : (h << 1);
    end
    return is32 ? c : {16'h0, h};
  endfunction

  // CR is only escaped right after an '@' went out on the escape path.
  function automatic logic needs_escape(input logic [7:0] c, input logic [7:0] prev);
    logic q;
    unique case (c)
      8'h0D, 8'h8D: q = (prev[6:0] == AT_LOW7);
      8'h10, 8'h11, 8'h13, 8'h90, 8'h91, 8'h93, 8'h18: q = 1'b1;
      default: q = 1'b0;
    endcase
    return q;
  endfunction

endpackage

FILE: rtl/zmodem_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// ZMODEM frame encoder core
// Turns header, data and subpacket-end items into the escaped serial byte
// stream of ZMODEM binary frames with CRC-16 or CRC-32.
// ----------------------------------------------------------------------------
// Usage:
// An item beat on in_data (mode, data_byte, frame_end) is taken into an input
// register. The encoder then builds every byte that the item causes (one to
// eleven) combinationally and loads them into an 11-byte output shifter.
// Bytes leave one per beat on out_data; last marks the final byte of an item.
// An item passes through the input register and then the output shifter.
// Items are paced by the output shifter, which gives out one byte per beat
// (1 or 2 bytes for a data byte, up to 11 for a subpacket end), and the
// next item is loaded in the cycle its last byte is taken; the input
// register takes an item while the shifter drains. When the receiver stalls,
// the shifter holds, the input register fills, and in_ready falls.
// The cfg channel writes crc32_en (always ready) and restarts the CRC; the
// user must write it only while the encoder is idle; the block does not enforce this.
// rst (synchronous) empties both registers, selects CRC-16, clears the CRC
// and the escape history.
// ----------------------------------------------------------------------------
module zmodem_frame_encoder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  zfe_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output zfe_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  zfe_pkg::in_t                   hold;
  logic                           hold_vld;
  logic [7:0]                     obuf [zfe_pkg::OBUF_DEPTH];
  logic [zfe_pkg::CNT_W-1:0]      cnt;
  logic [31:0]                    crc_accum;
  logic [7:0]                     last_sent_byte;
  logic                           crc32_en;

  logic                           load;
  logic                           pop;
  logic [7:0]                     seq [zfe_pkg::OBUF_DEPTH];
  logic [zfe_pkg::CNT_W-1:0]      seq_cnt;
  logic [31:0]                    crc_next;
  logic [7:0]                     lsb_next;

  assign pop       = out_valid && out_ready;
  assign load      = hold_vld && ((cnt == '0) || ((cnt == zfe_pkg::CNT_W'(1)) && out_ready));
  assign in_ready  = !hold_vld || load;
  assign cfg_ready = 1'b1;
  assign out_valid = (cnt != '0);
  assign out_data.out_byte = obuf[0];
  assign out_data.last     = (cnt == zfe_pkg::CNT_W'(1));

  // Byte builder: a raw prefix, up to four bytes through the escape path, then XON for ZCRCW.
  always_comb begin
    logic [7:0]                pre [3];
    logic [1:0]                npre;
    logic [3:0][7:0]           esc;
    logic [2:0]                nesc;
    logic                      xon;
    logic [7:0]                code;
    logic [31:0]               crc_f;
    logic [31:0]               crc_tx;
    logic [7:0]                b;
    logic [7:0]                lb;
    logic [zfe_pkg::CNT_W-1:0] pos;

    pre    = '{default: '0};
    npre   = '0;
    esc    = '0;
    nesc   = '0;
    xon    = 1'b0;
    code   = zfe_pkg::ZCRCE_B + {6'h0, hold.frame_end};
    crc_f  = crc_accum;
    crc_tx = '0;
    b      = '0;
    seq    = '{default: '0};
    crc_next = zfe_pkg::crc_init(crc32_en);

    unique case (hold.mode)
      zfe_pkg::MODE_DATA: begin
        esc[0]   = hold.data_byte;
        nesc     = 3'd1;
        crc_next = zfe_pkg::crc_fold(crc_accum, hold.data_byte, crc32_en);
      end
      zfe_pkg::MODE_HDR_BEG: begin
        pre[0]   = zfe_pkg::ZPAD_B;
        pre[1]   = zfe_pkg::ZDLE_B;
        pre[2]   = crc32_en ? zfe_pkg::ZBIN32_B : zfe_pkg::ZBIN_B;
        npre     = 2'd3;
        esc[0]   = hold.data_byte;
        nesc     = 3'd1;
        crc_next = zfe_pkg::crc_fold(zfe_pkg::crc_init(crc32_en), hold.data_byte, crc32_en);
      end
      zfe_pkg::MODE_HDR_END: begin
        crc_f = crc_accum;
      end
      zfe_pkg::MODE_SUB_END: begin
        pre[0] = zfe_pkg::ZDLE_B;
        pre[1] = code;
        npre   = 2'd2;
        crc_f  = zfe_pkg::crc_fold(crc_accum, code, crc32_en);
        xon    = (hold.frame_end == zfe_pkg::FE_ZCRCW);
      end
      default: begin
        crc_f = crc_accum;
      end
    endcase

    // CRC-32 goes out complemented, low byte first; CRC-16 high byte first.
    if (hold.mode == zfe_pkg::MODE_HDR_END || hold.mode == zfe_pkg::MODE_SUB_END) begin
      crc_tx = crc32_en ? ~crc_f : {16'h0, crc_f[7:0], crc_f[15:8]};
      esc    = crc_tx;
      nesc   = crc32_en ? 3'd4 : 3'd2;
    end

    for (int i = 0; i < 3; i++) begin
      seq[i] = pre[i];
    end
    pos = zfe_pkg::CNT_W'(npre);
    lb  = last_sent_byte;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nesc) begin
        b = esc[i];
        if (zfe_pkg::needs_escape(b, lb)) begin
          seq[pos] = zfe_pkg::ZDLE_B;
          pos      = pos + zfe_pkg::CNT_W'(1);
          b        = b ^ zfe_pkg::ESC_XOR;
        end
        seq[pos] = b;
        pos      = pos + zfe_pkg::CNT_W'(1);
        lb       = b;
      end
    end
    if (xon) begin
      seq[pos] = zfe_pkg::XON_B;
      pos      = pos + zfe_pkg::CNT_W'(1);
    end
    seq_cnt  = pos;
    lsb_next = lb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld       <= 1'b0;
      cnt            <= '0;
      crc_accum      <= '0;
      last_sent_byte <= '0;
      crc32_en       <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_vld <= 1'b1;
      end else if (load) begin
        hold_vld <= 1'b0;
      end

      if (load) begin
        cnt            <= seq_cnt;
        last_sent_byte <= lsb_next;
      end else if (pop) begin
        cnt <= cnt - zfe_pkg::CNT_W'(1);
      end

      // A register write restarts the CRC for the newly selected width.
      if (cfg_valid && cfg_ready) begin
        crc32_en  <= cfg_data;
        crc_accum <= zfe_pkg::crc_init(cfg_data);
      end else if (load) begin
        crc_accum <= crc_next;
      end
    end
  end

  // Payload registers: input hold and output shifter.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
    if (load) begin
      obuf <= seq;
    end else if (pop) begin
      for (int i = 0; i < zfe_pkg::OBUF_DEPTH - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ZMODEM frame encoder core testbench
// Drives header, data and subpacket-end items through the encoder while the
// sender pauses between bursts and the receiver stalls. The CRC mode is
// switched between phases. A scoreboard predicts every escaped byte of the
// stream and checks each output beat against it.
// ----------------------------------------------------------------------------

class encoded_stream_sb;
  bit            crc32_on;
  bit [31:0]     crc_acc;
  bit [7:0]      prev_sent;
  bit [7:0]      item_bytes[$];
  zfe_pkg::out_t expected_bytes[$];
  int            mismatches;
  int            reports;

  function new();
    crc32_on   = 1'b0;
    crc_acc    = 32'h0;
    prev_sent  = 8'h0;
    mismatches = 0;
    reports    = 0;
  endfunction

  function bit [31:0] crc_start();
    return crc32_on ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  // A register write restarts the CRC but keeps the escape history.
  function void set_crc32(bit en);
    crc32_on = en;
    crc_acc  = crc_start();
  endfunction

  function void fold_crc(bit [7:0] b);
    bit [31:0] c;
    bit [15:0] h;
    int        i;
    if (crc32_on) begin
      c = crc_acc ^ {24'h0, b};
      for (i = 0; i < 8; i++)
        c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
      crc_acc = c;
    end else begin
      h = crc_acc[15:0] ^ {b, 8'h00};
      for (i = 0; i < 8; i++)
        h = h[15] ? ((h << 1) ^ 16'h1021) : (h << 1);
      crc_acc = {16'h0, h};
    end
  endfunction

  function void send_escaped(bit [7:0] c);
    bit quote;
    case (c)
      8'h0D, 8'h8D: quote = (prev_sent[6:0] == 7'h40);
      8'h10, 8'h11, 8'h13, 8'h90, 8'h91, 8'h93, 8'h18: quote = 1'b1;
      default: quote = 1'b0;
    endcase
    if (quote) begin
      item_bytes.push_back(zfe_pkg::ZDLE_B);
      c = c ^ zfe_pkg::ESC_XOR;
    end
    item_bytes.push_back(c);
    prev_sent = c;
  endfunction

  function void send_crc();
    bit [31:0] c;
    int        i;
    if (crc32_on) begin
      c = ~crc_acc;
      for (i = 0; i < 4; i++) begin
        send_escaped(c[7:0]);
        c = c >> 8;
      end
    end else begin
      send_escaped(crc_acc[15:8]);
      send_escaped(crc_acc[7:0]);
    end
    crc_acc = crc_start();
  endfunction

  function void note_item(zfe_pkg::in_t it);
    bit [7:0]      code;
    zfe_pkg::out_t e;
    item_bytes.delete();
    code = zfe_pkg::ZCRCE_B + {6'h0, it.frame_end};
    case (it.mode)
      zfe_pkg::MODE_DATA: begin
        send_escaped(it.data_byte);
        fold_crc(it.data_byte);
      end
      zfe_pkg::MODE_HDR_BEG: begin
        item_bytes.push_back(zfe_pkg::ZPAD_B);
        item_bytes.push_back(zfe_pkg::ZDLE_B);
        item_bytes.push_back(crc32_on ? zfe_pkg::ZBIN32_B : zfe_pkg::ZBIN_B);
        send_escaped(it.data_byte);
        crc_acc = crc_start();
        fold_crc(it.data_byte);
      end
      zfe_pkg::MODE_HDR_END: begin
        send_crc();
      end
      default: begin
        item_bytes.push_back(zfe_pkg::ZDLE_B);
        item_bytes.push_back(code);
        fold_crc(code);
        send_crc();
        if (it.frame_end == zfe_pkg::FE_ZCRCW)
          item_bytes.push_back(zfe_pkg::XON_B);
      end
    endcase
    foreach (item_bytes[i]) begin
      e.out_byte = item_bytes[i];
      e.last     = (i == item_bytes.size() - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  function void fail_note(string field, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (reports < 100) begin
      reports++;
      $display("%0t: %s mismatch: expected %02h, got %02h", $time, field, want, got);
    end
  endfunction

  function void check_beat(zfe_pkg::out_t got);
    zfe_pkg::out_t want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (reports < 100) begin
        reports++;
        $display("%0t: beat with nothing pending: expected none, got %02h last %0b",
                 $time, got.out_byte, got.last);
      end
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        fail_note("out_byte", want.out_byte, got.out_byte);
      if (got.last !== want.last)
        fail_note("last", {7'h0, want.last}, {7'h0, got.last});
    end
  endfunction

  function int outstanding();
    return expected_bytes.size();
  endfunction
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 400;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  zfe_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  zfe_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_data  = 1'b0;

  encoded_stream_sb sb;
  int stall_cycles = 0;
  int burst_left   = 0;
  int rx_style     = 0;
  int rx_left      = 0;
  int rx_tick      = 0;

  zmodem_frame_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // The receiver switches between four stall styles, each held for a random run.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ((rx_tick % 4) == 0);
      default: out_ready <= ((rx_tick % 13) >= 5);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(in_data);
      if (out_valid && out_ready)
        sb.check_beat(out_data);
      if (cfg_valid && cfg_ready)
        sb.set_crc32(cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[zmodem_frame_encoder_core] ERROR");
        $finish;
      end
    end
  end

  function automatic zfe_pkg::in_t mk(logic [1:0] m, logic [7:0] d, logic [1:0] f);
    zfe_pkg::in_t it;
    it.mode      = m;
    it.data_byte = d;
    it.frame_end = f;
    return it;
  endfunction

  // Mostly random bytes, with the escaped codes and '@' and CR bytes mixed in.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 10))
        0: b = 8'h10;
        1: b = 8'h11;
        2: b = 8'h13;
        3: b = 8'h90;
        4: b = 8'h91;
        5: b = 8'h93;
        6: b = 8'h18;
        7: b = 8'h0D;
        8: b = 8'h8D;
        9: b = 8'h40;
        default: b = 8'hC0;
      endcase
    end
    return b;
  endfunction

  function automatic logic [1:0] any_fe();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic push_item(input zfe_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_items);
    int cnt;
    int k;
    int r;
    cnt = 0;
    while (cnt < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // Binary header: type, four header bytes, CRC.
        push_item(mk(zfe_pkg::MODE_HDR_BEG,
                     ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 20)) : pick_byte(),
                     any_fe()));
        for (k = 0; k < 4; k++)
          push_item(mk(zfe_pkg::MODE_DATA, pick_byte(), any_fe()));
        push_item(mk(zfe_pkg::MODE_HDR_END, 8'($urandom_range(0, 255)), any_fe()));
        cnt += 6;
      end else if (r < 85) begin
        k = $urandom_range(0, 16);
        repeat (k) push_item(mk(zfe_pkg::MODE_DATA, pick_byte(), any_fe()));
        push_item(mk(zfe_pkg::MODE_SUB_END, 8'($urandom_range(0, 255)), any_fe()));
        cnt += k + 1;
      end else begin
        push_item(mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), any_fe()));
        cnt++;
      end
    end
  endtask

  initial begin
    int p;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // CRC-16 frames: escaped type, data extremes, every escaped code, the CR rule.
    push_item(mk(zfe_pkg::MODE_HDR_BEG, 8'h18, 2'd3));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h00, 2'd3));
    push_item(mk(zfe_pkg::MODE_DATA, 8'hFF, 2'd0));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h40, 2'd1));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h0D, 2'd2));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h8D, 2'd3));
    push_item(mk(zfe_pkg::MODE_HDR_END, 8'hFF, 2'd2));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h10, 2'd0));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h11, 2'd1));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h13, 2'd2));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h90, 2'd0));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h91, 2'd1));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h93, 2'd2));
    push_item(mk(zfe_pkg::MODE_DATA, 8'hC0, 2'd0));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h8D, 2'd1));
    push_item(mk(zfe_pkg::MODE_SUB_END, 8'h00, 2'd0));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h7F, 2'd3));
    push_item(mk(zfe_pkg::MODE_SUB_END, 8'hFF, 2'd1));
    push_item(mk(zfe_pkg::MODE_SUB_END, 8'hA5, 2'd2));
    push_item(mk(zfe_pkg::MODE_SUB_END, 8'h5A, zfe_pkg::FE_ZCRCW));
    settle(4);

    write_cfg(1'b1);
    push_item(mk(zfe_pkg::MODE_HDR_BEG, 8'h0D, 2'd1));
    push_item(mk(zfe_pkg::MODE_DATA, 8'h00, 2'd2));
    push_item(mk(zfe_pkg::MODE_HDR_END, 8'h00, 2'd3));
    push_item(mk(zfe_pkg::MODE_DATA, 8'hAA, 2'd0));
    push_item(mk(zfe_pkg::MODE_SUB_END, 8'hFF, zfe_pkg::FE_ZCRCW));
    settle(4);
    write_cfg(1'b0);

    for (p = 0; p < 6; p++) begin
      run_phase(52);
      settle(4);
      if (p < 5)
        write_cfg(1'($urandom_range(0, 1)));
    end

    settle(8);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("[zmodem_frame_encoder_core] OK");
    else
      $display("[zmodem_frame_encoder_core] ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/zfe_pkg.sv
rtl/zmodem_frame_encoder_core.sv
bench/tb.sv
